// ===== hw/rtl/ctas_pkg.sv =====
// Package for the clock time and alarm set controller.
// Holds the command and field codes, the beat payload types and the BCD helpers.
// No dependencies; every other file of the block depends on it.
`default_nettype none

package ctas_pkg;

    localparam logic [2:0] CMD_SAMPLE = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_UP     = 3'd2;
    localparam logic [2:0] CMD_DOWN   = 3'd3;
    localparam logic [2:0] CMD_ALARM  = 3'd4;

    localparam logic [2:0] FIELD_NONE   = 3'd0;
    localparam logic [2:0] FIELD_HOUR   = 3'd1;
    localparam logic [2:0] FIELD_MINUTE = 3'd2;
    localparam logic [2:0] FIELD_SECOND = 3'd3;
    localparam logic [2:0] FIELD_DATE   = 3'd4;
    localparam logic [2:0] FIELD_MONTH  = 3'd5;
    localparam logic [2:0] FIELD_YEAR   = 3'd6;

    localparam logic [7:0] HOUR_MAX   = 8'd23;
    localparam logic [7:0] MINSEC_MAX = 8'd59;
    localparam logic [7:0] DATE_MAX   = 8'd31;
    localparam logic [7:0] MONTH_MAX  = 8'd12;
    localparam logic [7:0] YEAR_MAX   = 8'd99;
    localparam logic [3:0] UNITS_NONE = 4'hf;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] rtc_seconds;
        logic [7:0] rtc_minutes;
        logic [7:0] rtc_hours;
        logic [2:0] rtc_weekday;
        logic [7:0] rtc_date;
        logic [7:0] rtc_month;
        logic [7:0] rtc_year;
    } in_item_t;

    typedef struct packed {
        logic       buzzer_on;
        logic       write_strobe;
        logic [7:0] out_seconds;
        logic [7:0] out_minutes;
        logic [7:0] out_hours;
        logic [2:0] out_weekday;
        logic [7:0] out_date;
        logic [7:0] out_month;
        logic [7:0] out_year;
        logic [1:0] edit_state;
        logic [2:0] edit_field;
    } out_item_t;

    // Tens nibble times ten plus units nibble; an undecodable byte gives up to 165.
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'd0, b[7:4]};
        return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
    endfunction

    // Values here never exceed 99, so the reciprocal 205/2048 gives the exact quotient.
    function automatic logic [7:0] bcd_byte(input logic [7:0] v);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        prod = {8'd0, v} * 16'd205;
        q    = prod[14:11];
        r    = v - (({4'd0, q} << 3) + ({4'd0, q} << 1));
        return {q, r[3:0]};
    endfunction

    function automatic logic [7:0] adjust(input logic [7:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi, input logic up);
        logic [7:0] res;
        if (up)
        begin
            res = (v < hi) ? v + 8'd1 : lo;
        end
        else if (v > hi)
        begin
            res = hi;
        end
        else
        begin
            res = (v > lo) ? v - 8'd1 : hi;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ctas_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
// Depends on ctas_pkg for the payload types.
`default_nettype none

interface ctas_in_if;
    logic              valid;
    logic              ready;
    ctas_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ctas_out_if;
    logic               valid;
    logic               ready;
    ctas_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/clock_time_alarm_set_controller_unit.sv =====
// Time and alarm set controller of a desk clock.
// Input beats on in_ch carry a command (time sample or key event) and an RTC sample; every
// accepted beat produces exactly one result beat on out_ch with the buzzer level, an
// optional BCD write-back of the edited time and the current edit mode and field.
// The control state is updated at the edge that accepts the input beat, and the result
// is registered at that same edge, in the result register or, if that is full, the skid.
// Throughput is one beat per cycle with an empty skid, set by the single registered update.
// A two-deep output stage (result register plus skid register) keeps in_ch.ready high
// while one finished result waits; in_ch.ready drops only when both entries are full,
// i.e. when the receiver has stalled for two consecutive results.
// Reset clears the stored time and alarm to zero, silences the buzzer, sets the last
// seen seconds units to fifteen, returns to idle and empties the output stage.
// Depends on ctas_pkg and the interfaces in ctas_if.sv.
`default_nettype none

module clock_time_alarm_set_controller_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ctas_in_if.sink     in_ch,
    ctas_out_if.source  out_ch
);
    import ctas_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TIME  = 2'd1,
        MODE_ALARM = 2'd2
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [2:0] field_reg, field_next;
    logic [7:0] sec_reg, sec_next;
    logic [7:0] min_reg, min_next;
    logic [7:0] hour_reg, hour_next;
    logic [2:0] wday_reg, wday_next;
    logic [7:0] date_reg, date_next;
    logic [7:0] month_reg, month_next;
    logic [7:0] year_reg, year_next;
    logic [4:0] al_hour_reg, al_hour_next;
    logic [5:0] al_min_reg, al_min_next;
    logic [5:0] al_sec_reg, al_sec_next;
    logic       ringing_reg, ringing_next;
    logic [3:0] units_reg, units_next;

    out_item_t  out_data_reg, skid_data_reg, result;
    logic       out_valid_reg, skid_valid_reg;

    logic       accept;
    logic       take;
    logic       strobe;
    in_item_t   item;
    logic       up;
    logic [7:0] sel_byte, field_lo, field_hi, adj_byte;
    logic [3:0] field_inc;

    assign item   = in_ch.data;
    assign accept = in_ch.valid && in_ch.ready;
    assign take   = out_valid_reg && out_ch.ready;
    assign up     = (item.cmd == CMD_UP);

    assign in_ch.ready  = !skid_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Selected time field while editing: its stored byte and its legal range.
    always_comb
    begin
        case (field_reg)
            FIELD_HOUR:   begin sel_byte = hour_reg;  field_lo = 8'd0; field_hi = HOUR_MAX;   end
            FIELD_MINUTE: begin sel_byte = min_reg;   field_lo = 8'd0; field_hi = MINSEC_MAX; end
            FIELD_SECOND: begin sel_byte = sec_reg;   field_lo = 8'd0; field_hi = MINSEC_MAX; end
            FIELD_DATE:   begin sel_byte = date_reg;  field_lo = 8'd1; field_hi = DATE_MAX;   end
            FIELD_MONTH:  begin sel_byte = month_reg; field_lo = 8'd1; field_hi = MONTH_MAX;  end
            FIELD_YEAR:   begin sel_byte = year_reg;  field_lo = 8'd0; field_hi = YEAR_MAX;   end
            default:      begin sel_byte = 8'd0;      field_lo = 8'd0; field_hi = 8'd0;       end
        endcase
        adj_byte  = bcd_byte(adjust(bcd_value(sel_byte), field_lo, field_hi, up));
        field_inc = {1'b0, field_reg} + 4'd1;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        field_next   = field_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        wday_next    = wday_reg;
        date_next    = date_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        al_hour_next = al_hour_reg;
        al_min_next  = al_min_reg;
        al_sec_next  = al_sec_reg;
        ringing_next = ringing_reg;
        units_next   = units_reg;
        strobe       = 1'b0;

        case (mode_reg)
            MODE_IDLE:
            begin
                if (item.cmd == CMD_SAMPLE)
                begin
                    sec_next   = item.rtc_seconds;
                    min_next   = item.rtc_minutes;
                    hour_next  = item.rtc_hours;
                    wday_next  = item.rtc_weekday;
                    date_next  = item.rtc_date;
                    month_next = item.rtc_month;
                    year_next  = item.rtc_year;
                    // The alarm is only checked once per new seconds units digit.
                    if (item.rtc_seconds[3:0] != units_reg)
                    begin
                        units_next = item.rtc_seconds[3:0];
                        if (bcd_value(item.rtc_hours) == {3'd0, al_hour_reg} &&
                            bcd_value(item.rtc_minutes) == {2'd0, al_min_reg} &&
                            bcd_value(item.rtc_seconds) == {2'd0, al_sec_reg})
                        begin
                            ringing_next = 1'b1;
                        end
                    end
                end
                else if (item.cmd == CMD_SET)
                begin
                    mode_next  = MODE_TIME;
                    field_next = FIELD_HOUR;
                end
                else if (item.cmd == CMD_ALARM)
                begin
                    if (ringing_reg)
                    begin
                        ringing_next = 1'b0;
                    end
                    else
                    begin
                        mode_next  = MODE_ALARM;
                        field_next = FIELD_HOUR;
                    end
                end
            end
            MODE_TIME:
            begin
                if (item.cmd inside {CMD_UP, CMD_DOWN} &&
                    field_reg inside {[FIELD_HOUR:FIELD_YEAR]})
                begin
                    case (field_reg)
                        FIELD_HOUR:   hour_next  = adj_byte;
                        FIELD_MINUTE: min_next   = adj_byte;
                        FIELD_SECOND: sec_next   = adj_byte;
                        FIELD_DATE:   date_next  = adj_byte;
                        FIELD_MONTH:  month_next = adj_byte;
                        default:      year_next  = adj_byte;
                    endcase
                end
                else if (item.cmd == CMD_SET)
                begin
                    field_next = field_inc[2:0];
                    if (field_inc[2:0] > FIELD_YEAR || field_inc[2:0] == FIELD_NONE)
                    begin
                        strobe = 1'b1;
                    end
                end
                else if (item.cmd == CMD_ALARM)
                begin
                    strobe = 1'b1;
                end
                if (strobe)
                begin
                    mode_next  = MODE_IDLE;
                    field_next = FIELD_NONE;
                end
            end
            MODE_ALARM:
            begin
                if (item.cmd inside {CMD_UP, CMD_DOWN})
                begin
                    if (field_reg == FIELD_HOUR)
                    begin
                        al_hour_next = 5'(adjust({3'd0, al_hour_reg}, 8'd0, HOUR_MAX, up));
                    end
                    else if (field_reg == FIELD_MINUTE)
                    begin
                        al_min_next = 6'(adjust({2'd0, al_min_reg}, 8'd0, MINSEC_MAX, up));
                    end
                    else if (field_reg == FIELD_SECOND)
                    begin
                        al_sec_next = 6'(adjust({2'd0, al_sec_reg}, 8'd0, MINSEC_MAX, up));
                    end
                end
                else if (item.cmd == CMD_ALARM)
                begin
                    if (field_inc > {1'b0, FIELD_SECOND})
                    begin
                        mode_next  = MODE_IDLE;
                        field_next = FIELD_NONE;
                    end
                    else
                    begin
                        field_next = field_inc[2:0];
                    end
                end
                else if (item.cmd == CMD_SET)
                begin
                    mode_next  = MODE_IDLE;
                    field_next = FIELD_NONE;
                end
            end
            default:
            begin
                mode_next  = MODE_IDLE;
                field_next = FIELD_NONE;
            end
        endcase

        result              = '0;
        result.buzzer_on    = ringing_next;
        result.write_strobe = strobe;
        if (strobe)
        begin
            result.out_seconds = sec_next;
            result.out_minutes = min_next;
            result.out_hours   = hour_next;
            result.out_weekday = wday_next;
            result.out_date    = date_next;
            result.out_month   = month_next;
            result.out_year    = year_next;
        end
        result.edit_state = mode_next;
        result.edit_field = field_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            field_reg      <= FIELD_NONE;
            sec_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
            wday_reg       <= '0;
            date_reg       <= '0;
            month_reg      <= '0;
            year_reg       <= '0;
            al_hour_reg    <= '0;
            al_min_reg     <= '0;
            al_sec_reg     <= '0;
            ringing_reg    <= 1'b0;
            units_reg      <= UNITS_NONE;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_data_reg   <= '0;
            skid_data_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg    <= mode_next;
                field_reg   <= field_next;
                sec_reg     <= sec_next;
                min_reg     <= min_next;
                hour_reg    <= hour_next;
                wday_reg    <= wday_next;
                date_reg    <= date_next;
                month_reg   <= month_next;
                year_reg    <= year_next;
                al_hour_reg <= al_hour_next;
                al_min_reg  <= al_min_next;
                al_sec_reg  <= al_sec_next;
                ringing_reg <= ringing_next;
                units_reg   <= units_next;
            end

            // The skid entry is always older than a new beat, so it moves up first.
            if (!out_valid_reg || take)
            begin
                if (skid_valid_reg)
                begin
                    out_data_reg   <= skid_data_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else if (accept)
                begin
                    out_data_reg  <= result;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                skid_data_reg  <= result;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/clock_time_alarm_set_controller_unit_tb.sv =====
// Self-checking testbench for the desk clock time and alarm set controller.
// Drives command beats through ctas_in_if, checks every result beat on ctas_out_if
// against a behavioral tracker; depends on ctas_pkg, ctas_if.sv and the block's RTL.
module clock_time_alarm_set_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctas_pkg::*;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_TIME  = 2'd1;
    localparam logic [1:0] MODE_ALARM = 2'd2;

    // Command codes the block has no use for.
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int TARGET_ITEMS = 1400;
    localparam int QUIET_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 4;
    localparam int DAY_SECONDS  = 86400;

    class clock_setting_tracker;
        logic [7:0] time_bytes [7];
        int         alarm_hour;
        int         alarm_minute;
        int         alarm_second;
        logic       ringing;
        logic [3:0] last_units;
        logic [1:0] mode;
        logic [2:0] field;
        out_item_t  pending_outputs [$];
        int         failures;

        function new();
            foreach (time_bytes[i])
            begin
                time_bytes[i] = '0;
            end
            alarm_hour   = 0;
            alarm_minute = 0;
            alarm_second = 0;
            ringing      = 1'b0;
            last_units   = UNITS_NONE;
            mode         = MODE_IDLE;
            field        = FIELD_NONE;
            failures     = 0;
        endfunction

        static function int from_bcd(logic [7:0] b);
            return int'(b[7:4]) * 10 + int'(b[3:0]);
        endfunction

        static function logic [7:0] to_bcd(int v);
            logic [3:0] tens;
            logic [3:0] units;
            tens  = 4'(v / 10);
            units = 4'(v % 10);
            return {tens, units};
        endfunction

        // Wraps at both ends; a value above the top counts as past the top.
        static function int wrap_step(int v, int lo, int hi, logic up);
            if (up)
            begin
                return (v < hi) ? v + 1 : lo;
            end
            if (v > hi)
            begin
                return hi;
            end
            return (v > lo) ? v - 1 : hi;
        endfunction

        function void note_command(in_item_t item);
            out_item_t res;
            logic      strobe;
            logic      up;
            int        idx;
            int        lo;
            int        hi;
            strobe = 1'b0;
            up     = (item.cmd == CMD_UP);
            case (mode)
                MODE_IDLE:
                begin
                    if (item.cmd == CMD_SAMPLE)
                    begin
                        time_bytes[0] = item.rtc_seconds;
                        time_bytes[1] = item.rtc_minutes;
                        time_bytes[2] = item.rtc_hours;
                        time_bytes[3] = {5'd0, item.rtc_weekday};
                        time_bytes[4] = item.rtc_date;
                        time_bytes[5] = item.rtc_month;
                        time_bytes[6] = item.rtc_year;
                        // The alarm is only compared when the seconds units digit moves.
                        if (item.rtc_seconds[3:0] != last_units)
                        begin
                            last_units = item.rtc_seconds[3:0];
                            if (from_bcd(time_bytes[2]) == alarm_hour &&
                                from_bcd(time_bytes[1]) == alarm_minute &&
                                from_bcd(time_bytes[0]) == alarm_second)
                            begin
                                ringing = 1'b1;
                            end
                        end
                    end
                    else if (item.cmd == CMD_SET)
                    begin
                        mode  = MODE_TIME;
                        field = FIELD_HOUR;
                    end
                    else if (item.cmd == CMD_ALARM)
                    begin
                        if (ringing)
                        begin
                            ringing = 1'b0;
                        end
                        else
                        begin
                            mode  = MODE_ALARM;
                            field = FIELD_HOUR;
                        end
                    end
                end
                MODE_TIME:
                begin
                    if (item.cmd == CMD_UP || item.cmd == CMD_DOWN)
                    begin
                        case (field)
                            FIELD_HOUR:   begin idx = 2; lo = 0; hi = HOUR_MAX;   end
                            FIELD_MINUTE: begin idx = 1; lo = 0; hi = MINSEC_MAX; end
                            FIELD_SECOND: begin idx = 0; lo = 0; hi = MINSEC_MAX; end
                            FIELD_DATE:   begin idx = 4; lo = 1; hi = DATE_MAX;   end
                            FIELD_MONTH:  begin idx = 5; lo = 1; hi = MONTH_MAX;  end
                            default:      begin idx = 6; lo = 0; hi = YEAR_MAX;   end
                        endcase
                        time_bytes[idx] = to_bcd(wrap_step(from_bcd(time_bytes[idx]),
                                                           lo, hi, up));
                    end
                    else if (item.cmd == CMD_SET)
                    begin
                        if (field == FIELD_YEAR)
                        begin
                            strobe = 1'b1;
                        end
                        else
                        begin
                            field = field + 3'd1;
                        end
                    end
                    else if (item.cmd == CMD_ALARM)
                    begin
                        strobe = 1'b1;
                    end
                    if (strobe)
                    begin
                        mode  = MODE_IDLE;
                        field = FIELD_NONE;
                    end
                end
                default:
                begin
                    if (item.cmd == CMD_UP || item.cmd == CMD_DOWN)
                    begin
                        case (field)
                            FIELD_HOUR:   alarm_hour   = wrap_step(alarm_hour, 0, HOUR_MAX, up);
                            FIELD_MINUTE: alarm_minute = wrap_step(alarm_minute, 0, MINSEC_MAX,
                                                                   up);
                            default:      alarm_second = wrap_step(alarm_second, 0, MINSEC_MAX,
                                                                   up);
                        endcase
                    end
                    else if (item.cmd == CMD_ALARM)
                    begin
                        if (field == FIELD_SECOND)
                        begin
                            mode  = MODE_IDLE;
                            field = FIELD_NONE;
                        end
                        else
                        begin
                            field = field + 3'd1;
                        end
                    end
                    else if (item.cmd == CMD_SET)
                    begin
                        mode  = MODE_IDLE;
                        field = FIELD_NONE;
                    end
                end
            endcase

            res              = '0;
            res.buzzer_on    = ringing;
            res.write_strobe = strobe;
            if (strobe)
            begin
                res.out_seconds = time_bytes[0];
                res.out_minutes = time_bytes[1];
                res.out_hours   = time_bytes[2];
                res.out_weekday = time_bytes[3][2:0];
                res.out_date    = time_bytes[4];
                res.out_month   = time_bytes[5];
                res.out_year    = time_bytes[6];
            end
            res.edit_state = mode;
            res.edit_field = field;
            pending_outputs.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_outputs.size() == 0)
            begin
                failures++;
                $display("%0t: result beat with none expected, expected nothing, actual %p",
                         $time, got);
                return;
            end
            want = pending_outputs.pop_front();
            compare_field("buzzer_on", want.buzzer_on, got.buzzer_on);
            compare_field("write_strobe", want.write_strobe, got.write_strobe);
            compare_field("out_seconds", want.out_seconds, got.out_seconds);
            compare_field("out_minutes", want.out_minutes, got.out_minutes);
            compare_field("out_hours", want.out_hours, got.out_hours);
            compare_field("out_weekday", want.out_weekday, got.out_weekday);
            compare_field("out_date", want.out_date, got.out_date);
            compare_field("out_month", want.out_month, got.out_month);
            compare_field("out_year", want.out_year, got.out_year);
            compare_field("edit_state", want.edit_state, got.edit_state);
            compare_field("edit_field", want.edit_field, got.edit_field);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ctas_in_if  in_ch ();
    ctas_out_if out_ch ();

    clock_time_alarm_set_controller_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    clock_setting_tracker tracker = new();

    int   meaningful_items = 0;
    int   results_checked  = 0;
    int   burst_left       = 0;
    int   quiet_cycles     = 0;
    logic hold_off_active  = 1'b0;

    always #1 clk = ~clk;

    function automatic in_item_t key_item(logic [2:0] cmd);
        in_item_t it;
        it.cmd         = cmd;
        it.rtc_seconds = 8'($urandom_range(0, 153));
        it.rtc_minutes = 8'($urandom_range(0, 153));
        it.rtc_hours   = 8'($urandom_range(0, 153));
        it.rtc_weekday = 3'($urandom_range(0, 7));
        it.rtc_date    = 8'($urandom_range(0, 153));
        it.rtc_month   = 8'($urandom_range(0, 153));
        it.rtc_year    = 8'($urandom_range(0, 153));
        return it;
    endfunction

    function automatic in_item_t sample_at(int day_second);
        in_item_t it;
        it.cmd         = CMD_SAMPLE;
        it.rtc_seconds = clock_setting_tracker::to_bcd(day_second % 60);
        it.rtc_minutes = clock_setting_tracker::to_bcd((day_second / 60) % 60);
        it.rtc_hours   = clock_setting_tracker::to_bcd(day_second / 3600);
        it.rtc_weekday = 3'($urandom_range(0, 7));
        it.rtc_date    = clock_setting_tracker::to_bcd($urandom_range(1, 31));
        it.rtc_month   = clock_setting_tracker::to_bcd($urandom_range(1, 12));
        it.rtc_year    = clock_setting_tracker::to_bcd($urandom_range(0, 99));
        // Now and then the RTC hands over a byte that is not clean BCD.
        if ($urandom_range(0, 19) == 0)
        begin
            it.rtc_seconds = 8'($urandom_range(0, 153));
        end
        if ($urandom_range(0, 19) == 0)
        begin
            it.rtc_hours = 8'($urandom_range(0, 153));
        end
        return it;
    endfunction

    // Offers one beat and returns at the edge that accepts it; valid stays high afterwards.
    task automatic send_beat(in_item_t item);
        logic ignored;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (!hold_off_active && $urandom_range(0, 3) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        ignored = (item.cmd > CMD_ALARM) ||
                  (tracker.mode == MODE_IDLE && (item.cmd == CMD_UP || item.cmd == CMD_DOWN)) ||
                  (tracker.mode != MODE_IDLE && item.cmd == CMD_SAMPLE);
        if (!ignored)
        begin
            meaningful_items++;
        end
        tracker.note_command(item);
    endtask

    task automatic return_to_idle();
        if (tracker.mode == MODE_TIME)
        begin
            send_beat(key_item(CMD_ALARM));
        end
        else if (tracker.mode == MODE_ALARM)
        begin
            send_beat(key_item(CMD_SET));
        end
    endtask

    // A stretch of RTC samples, usually running up to and across the alarm time.
    task automatic time_run();
        int n;
        int t;
        return_to_idle();
        n = $urandom_range(3, 25);
        if ($urandom_range(0, 9) < 7)
        begin
            t = tracker.alarm_hour * 3600 + tracker.alarm_minute * 60 + tracker.alarm_second
                + DAY_SECONDS - $urandom_range(0, 4);
        end
        else
        begin
            t = $urandom_range(0, DAY_SECONDS - 1);
        end
        repeat (n)
        begin
            send_beat(sample_at(t % DAY_SECONDS));
            if ($urandom_range(0, 3) != 0)
            begin
                t++;
            end
            if (tracker.ringing && $urandom_range(0, 4) == 0)
            begin
                send_beat(key_item(CMD_ALARM));
            end
        end
    endtask

    task automatic time_edit_session();
        int presses;
        int pick;
        return_to_idle();
        send_beat(key_item(CMD_SET));
        while (tracker.mode == MODE_TIME)
        begin
            presses = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            repeat (presses)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    send_beat(key_item(CMD_SAMPLE));
                end
                else if (pick == 1)
                begin
                    send_beat(key_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI))));
                end
                else
                begin
                    send_beat(key_item(pick < 11 ? CMD_UP : CMD_DOWN));
                end
            end
            send_beat(key_item($urandom_range(0, 9) == 0 ? CMD_ALARM : CMD_SET));
        end
    endtask

    task automatic alarm_edit_session();
        int presses;
        int pick;
        return_to_idle();
        if (tracker.ringing)
        begin
            send_beat(key_item(CMD_ALARM));
        end
        send_beat(key_item(CMD_ALARM));
        while (tracker.mode == MODE_ALARM)
        begin
            presses = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            repeat (presses)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    send_beat(key_item(CMD_SAMPLE));
                end
                else
                begin
                    send_beat(key_item(pick < 10 ? CMD_UP : CMD_DOWN));
                end
            end
            send_beat(key_item($urandom_range(0, 6) == 0 ? CMD_SET : CMD_ALARM));
        end
    endtask

    initial
    begin
        in_item_t   item;
        logic [2:0] idle_keys [5];
        logic [2:0] edit_walk [25];

        idle_keys = '{CMD_ALARM, CMD_UP, CMD_DOWN, CMD_SPARE_LO, CMD_SPARE_HI};
        edit_walk = '{
            CMD_SET, CMD_DOWN, CMD_UP, CMD_SAMPLE, CMD_SET, CMD_UP, CMD_SET, CMD_DOWN,
            CMD_SET, CMD_DOWN, CMD_SET, CMD_UP, CMD_SET, CMD_SET, CMD_SET, CMD_ALARM,
            CMD_ALARM, CMD_DOWN, CMD_ALARM, CMD_UP, CMD_ALARM, CMD_DOWN, CMD_ALARM,
            CMD_ALARM, CMD_SET};

        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An all-zero sample equals the cleared alarm and must start the buzzer.
        item     = '0;
        item.cmd = CMD_SAMPLE;
        send_beat(item);
        // Silence it, then keys and codes that idle ignores.
        foreach (idle_keys[i])
        begin
            send_beat(key_item(idle_keys[i]));
        end
        // Stored time with fields above the top and a date below the bottom.
        item = '{CMD_SAMPLE, 8'h75, 8'h99, 8'h99, 3'd7, 8'h00, 8'h99, 8'h99};
        send_beat(item);
        // Walk every time field, leave by set and by the alarm key, then edit the alarm.
        foreach (edit_walk[i])
        begin
            send_beat(key_item(edit_walk[i]));
        end

        while (meaningful_items < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: time_run();
                4, 5:       time_edit_session();
                6, 7:       alarm_edit_session();
                8:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        send_beat(key_item(3'($urandom_range(0, 7))));
                    end
                end
                default:    send_beat(key_item(CMD_ALARM));
            endcase
        end
        in_ch.valid <= 1'b0;

        while (tracker.pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
        begin
            $display("clock_time_alarm_set_controller_unit regression: pass");
        end
        else
        begin
            $display("clock_time_alarm_set_controller_unit regression: fail");
        end
        $finish;
    end

    // Result side: checks each accepted beat and throttles ready in phases of its own.
    initial
    begin
        int phase_left;
        int ready_pct;
        int hold_left;
        int holds_done;
        phase_left = 0;
        ready_pct  = 100;
        hold_left  = 0;
        holds_done = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                tracker.check_result(out_ch.data);
                results_checked++;
            end
            // Two long hold-offs let the output stage fill and push back on the input.
            if (hold_left == 0 && holds_done < 2 && results_checked >= 400 + 500 * holds_done)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(5, 80);
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 50;
                    default: ready_pct = 20;
                endcase
            end
            phase_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
            end
            hold_off_active = (hold_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("clock_time_alarm_set_controller_unit regression: fail");
                $finish;
            end
        end
    end

endmodule
